>>> rtl/nfht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfht_pkg
// Shared types and constants of the namespaced feature hash tokenizer.
// ----------------------------------------------------------------------------
package nfht_pkg;

	localparam int TABLE_BITS = 18;
	localparam int WORD_BITS  = 5;
	localparam int WORD_W     = 1 << WORD_BITS;
	localparam int ROW_BITS   = TABLE_BITS - WORD_BITS;
	localparam int ROWS       = 1 << ROW_BITS;
	localparam int CFG_W      = 5;

	localparam logic [TABLE_BITS-1:0] HASH_SEED = TABLE_BITS'(17);
	localparam logic [CFG_W-1:0]      BITS_MAX  = CFG_W'(TABLE_BITS);
	localparam logic [CFG_W-1:0]      BITS_RST  = CFG_W'(18);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       line_last;
	} nfht_in_t;

	typedef struct packed {
		logic                  feature_valid;
		logic [TABLE_BITS-1:0] feature_index;
		logic                  index_was_new;
		logic                  line_done;
		logic                  label_value;
	} nfht_out_t;

	// request from the tokenizer to the presence map
	typedef struct packed {
		logic                  feat;
		logic [TABLE_BITS-1:0] idx;
		logic                  line_done;
		logic                  label;
	} nfht_req_t;

endpackage

>>> rtl/nfht_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfht_tokenizer
// Per-byte token scanner: label decode, namespace seed and rolling hash.
// ----------------------------------------------------------------------------
module nfht_tokenizer import nfht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             step,
	input  nfht_in_t         in_data,
	output logic             req_valid,
	output nfht_req_t        req
);

	typedef enum logic [4:0] {
		LD_NONE       = 5'b00001,
		LD_WANT_ONE   = 5'b00010,
		LD_ONE_SO_FAR = 5'b00100,
		LD_ONE        = 5'b01000,
		LD_ZERO       = 5'b10000
	} ld_state_t;

	logic [CFG_W-1:0]      index_bits_q;
	logic [TABLE_BITS-1:0] seed_q;
	logic [TABLE_BITS-1:0] hash_q;
	logic                  inside_q;
	logic                  ns_q;
	logic                  pend_q;
	logic [1:0]            pos_q;
	ld_state_t             ld_q;

	ld_state_t             ld_d;
	logic [7:0]            b;
	logic                  is_sp;
	logic                  is_bar;
	logic                  ws;
	logic                  dig;
	logic [TABLE_BITS-1:0] base;
	logic [TABLE_BITS-1:0] new_hash;
	logic [TABLE_BITS-1:0] fin_hash;
	logic                  fin_inside;
	logic                  fin_ns;
	logic                  finish;
	logic                  emit;
	logic [CFG_W-1:0]      bits_sat;
	logic [TABLE_BITS-1:0] mask;

	always_comb begin
		b      = in_data.text_byte;
		is_sp  = (b == CH_SPACE);
		is_bar = (b == CH_BAR);
		ws     = is_sp || (b >= CH_TAB && b <= CH_CR);
		dig    = (b >= CH_ZERO && b <= CH_NINE);
	end

	// label decode over the first two bytes
	always_comb begin
		ld_d = ld_q;
		case (pos_q)
			2'd0: begin
				if (ws || b == CH_PLUS || b == CH_ZERO)
					ld_d = LD_WANT_ONE;
				else if (b == CH_ONE)
					ld_d = LD_ONE_SO_FAR;
				else
					ld_d = LD_ZERO;
			end
			2'd1: begin
				case (ld_q)
					LD_WANT_ONE:   ld_d = (b == CH_ONE) ? LD_ONE : LD_ZERO;
					LD_ONE_SO_FAR: ld_d = dig ? LD_ZERO : LD_ONE;
					default:       ld_d = LD_ZERO;
				endcase
			end
			default: ld_d = ld_q;
		endcase
	end

	// h*31 + signed byte, modulo the table width
	always_comb begin
		if (inside_q)
			base = hash_q;
		else if (is_bar)
			base = HASH_SEED;
		else
			base = seed_q;
		new_hash = (base << 5) - base + {{(TABLE_BITS-8){b[7]}}, b};
	end

	always_comb begin
		bits_sat = (index_bits_q > BITS_MAX) ? BITS_MAX : index_bits_q;
		for (int i = 0; i < TABLE_BITS; i++)
			mask[i] = (CFG_W'(i) < bits_sat);
	end

	always_comb begin
		fin_hash   = is_sp ? hash_q : new_hash;
		fin_inside = is_sp ? inside_q : 1'b1;
		fin_ns     = (is_sp || inside_q) ? ns_q : is_bar;
		finish     = is_sp || in_data.line_last;
		emit       = finish && fin_inside && !fin_ns && !pend_q;

		req_valid     = step && (emit || in_data.line_last);
		req.feat      = emit;
		req.idx       = emit ? (fin_hash & mask) : '0;
		req.line_done = in_data.line_last;
		req.label     = in_data.line_last && (ld_d == LD_ONE || ld_d == LD_ONE_SO_FAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= BITS_RST;
		end else if (cfg_valid) begin
			index_bits_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= HASH_SEED;
			hash_q   <= HASH_SEED;
			inside_q <= 1'b0;
			ns_q     <= 1'b0;
			pend_q   <= 1'b1;
			pos_q    <= 2'd0;
			ld_q     <= LD_NONE;
		end else if (step) begin
			if (in_data.line_last) begin
				seed_q   <= HASH_SEED;
				hash_q   <= HASH_SEED;
				inside_q <= 1'b0;
				ns_q     <= 1'b0;
				pend_q   <= 1'b1;
				pos_q    <= 2'd0;
				ld_q     <= LD_NONE;
			end else begin
				ld_q <= ld_d;
				if (pos_q != 2'd2)
					pos_q <= pos_q + 2'd1;
				if (is_sp) begin
					inside_q <= 1'b0;
					ns_q     <= 1'b0;
					if (inside_q && ns_q)
						seed_q <= hash_q;
					if (inside_q && !ns_q)
						pend_q <= 1'b0;
				end else begin
					hash_q   <= new_hash;
					inside_q <= 1'b1;
					if (!inside_q) begin
						ns_q <= is_bar;
						if (is_bar)
							seed_q <= HASH_SEED;
					end
				end
			end
		end
	end

endmodule

>>> rtl/nfht_seen_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfht_seen_map
// Presence bitmap in a word-wide RAM: read, set bit, write back, output stage.
// ----------------------------------------------------------------------------
module nfht_seen_map import nfht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  nfht_req_t req,
	output logic      req_ready,
	output logic      busy,
	output logic      out_valid,
	input  logic      out_stall,
	output nfht_out_t out_data
);

	logic [WORD_W-1:0]   mem [ROWS];

	logic                clr_busy_q;
	logic [ROW_BITS-1:0] clr_row_q;

	logic                vld_s1;
	nfht_req_t           req_s1;
	logic [WORD_W-1:0]   rd_data_q;

	logic                wr_vld_q;
	logic [ROW_BITS-1:0] wr_row_q;
	logic [WORD_W-1:0]   wr_data_q;

	logic                out_vld_q;
	nfht_out_t           out_q;

	logic                s1_move;
	logic                take;
	logic [ROW_BITS-1:0] s1_row;
	logic [WORD_W-1:0]   row_cur;
	logic [WORD_W-1:0]   row_new;
	logic                was_new;
	logic                mem_we;
	logic [ROW_BITS-1:0] mem_wa;
	logic [WORD_W-1:0]   mem_wd;

	always_comb begin
		s1_move   = vld_s1 && (!out_vld_q || !out_stall);
		req_ready = !clr_busy_q && (!vld_s1 || s1_move);
		take      = req_valid && req_ready;
		busy      = clr_busy_q;

		s1_row  = req_s1.idx[TABLE_BITS-1:WORD_BITS];
		// the write that landed with this read is not in the read data
		row_cur = (wr_vld_q && wr_row_q == s1_row) ? wr_data_q : rd_data_q;
		was_new = !row_cur[req_s1.idx[WORD_BITS-1:0]];
		row_new = row_cur | (WORD_W'(1) << req_s1.idx[WORD_BITS-1:0]);

		mem_we = clr_busy_q || (s1_move && req_s1.feat);
		mem_wa = clr_busy_q ? clr_row_q : s1_row;
		mem_wd = clr_busy_q ? '0 : row_new;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (take)
			rd_data_q <= mem[req.idx[TABLE_BITS-1:WORD_BITS]];
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + ROW_BITS'(1);
			if (&clr_row_q)
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			req_s1 <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (s1_move && req_s1.feat) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && req_s1.feat) begin
			wr_row_q  <= s1_row;
			wr_data_q <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.feature_valid <= req_s1.feat;
			out_q.feature_index <= req_s1.idx;
			out_q.index_was_new <= req_s1.feat && was_new;
			out_q.line_done     <= req_s1.line_done;
			out_q.label_value   <= req_s1.label;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

>>> rtl/namespaced_feature_hash_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// namespaced_feature_hash_tokenizer
// Splits text lines into tokens, hashes them per namespace and marks each
// feature index in a presence bitmap.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | nfht_in_t  (text_byte, line_last)
//  out     | out_valid / out_stall | nfht_out_t (feature and line result)
//  cfg     | cfg_valid / cfg_ready | index_bits, 5 bits
//
//  one byte per cycle while in_stall is low; each result passes through the
//  bitmap read, then set-and-write-back into the output register
//  after reset the bitmap is cleared one 32-bit row a cycle: in_stall is
//  high until all 8192 rows are clear
//  bytes with no result are absorbed without touching the bitmap
//  an output stall backs up through the read stage into in_stall
// ----------------------------------------------------------------------------
module namespaced_feature_hash_tokenizer import nfht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  nfht_in_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output nfht_out_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic      step;
	logic      req_valid;
	logic      req_ready;
	logic      busy;
	nfht_req_t req;

	assign in_stall  = busy || !req_ready;
	assign step      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	nfht_tokenizer u_tok (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.step      (step),
		.in_data   (in_data),
		.req_valid (req_valid),
		.req       (req)
	);

	nfht_seen_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
